### hw/rtl/erm_pkg.sv
// Package for the event rate meter: sizes, codes, payload structs and the
// sequencer state type. Used by every module of the block; no dependencies.
package erm_pkg;

    localparam int RING_DEPTH   = 1024;
    localparam int PTR_BITS     = $clog2(RING_DEPTH);
    localparam int CNT_BITS     = PTR_BITS + 1;
    localparam int TIME_BITS    = 32;
    localparam int DIV_BITS     = TIME_BITS + 2;
    localparam int STEP_BITS    = $clog2(DIV_BITS + 1);
    localparam int RATE_BITS    = 22;
    localparam int WIN_BITS     = 11;
    localparam int RECENT_BITS  = 17;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_BITS     = 32;

    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;

    // The hour number is (now / 16) / 225, taken by a reciprocal multiply that
    // may come out one low; one compare and subtract corrects it.
    localparam int          HQ_BITS         = TIME_BITS - 11;
    localparam logic [63:0] HOUR_RECIP_WIDE = (64'd1 << (TIME_BITS + 4)) / 64'd225;
    localparam logic [TIME_BITS-4:0] HOUR_RECIP = HOUR_RECIP_WIDE[TIME_BITS-4:0];

    localparam logic [1:0] OP_ADD     = 2'd0;
    localparam logic [1:0] OP_REFRESH = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;
    localparam logic [1:0] OP_SPARE   = 2'd3;

    localparam logic [CFG_IDX_BITS-1:0] CFG_SHORT_WIN   = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LONG_WIN    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_RECENT_SECS = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_START_TIME  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_START_VALID = 3'd4;

    typedef struct packed {
        logic [1:0]           op;
        logic [TIME_BITS-1:0] event_time;
        logic [TIME_BITS-1:0] now_time;
    } t_in_item;

    typedef struct packed {
        logic [RATE_BITS-1:0] short_rate;
        logic [RATE_BITS-1:0] long_rate;
        logic [CNT_BITS-1:0]  recent_count;
        logic [CNT_BITS-1:0]  hour_count;
        logic [RATE_BITS-1:0] average_rate;
        logic [CNT_BITS-1:0]  total_events;
    } t_out_item;

    typedef struct packed {
        logic                 add;
        logic                 clear;
        logic [TIME_BITS-1:0] event_time;
        logic [TIME_BITS-1:0] now_time;
    } t_cmd;

    typedef enum logic [4:0] {
        S_IDLE, S_APPLY, S_HDIV, S_HWAIT, S_RNEW, S_RSHORT, S_RLONG, S_GOTL,
        S_DSHORT, S_WSHORT, S_DLONG, S_WLONG, S_DAVG, S_WAVG, S_WADDR, S_WCMP,
        S_DONE
    } t_state;

endpackage

### hw/rtl/erm_front.sv
// Front end of the event rate meter: a two-entry input queue that decodes
// each accepted item into a command for the back end. Depends on erm_pkg.
module erm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  erm_pkg::t_in_item i_item,
    output logic              o_cmd_valid,
    output erm_pkg::t_cmd     o_cmd,
    input  logic              i_cmd_take
);
    erm_pkg::t_cmd r_q [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;
    erm_pkg::t_cmd n_cmd;
    logic          wr;
    logic          rd;

    always_comb begin
        n_cmd.add        = (i_item.op == erm_pkg::OP_ADD);
        n_cmd.clear      = (i_item.op == erm_pkg::OP_CLEAR);
        n_cmd.event_time = i_item.event_time;
        n_cmd.now_time   = i_item.now_time;
    end

    assign full        = (r_cnt == 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign wr          = push && !full;
    assign rd          = i_cmd_take && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_q[r_wp] <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) begin
                r_wp <= !r_wp;
            end
            if (rd) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end
endmodule

### hw/rtl/erm_div.sv
// Restoring divider of the event rate meter, one quotient bit per cycle.
// Gives the quotient. Depends on erm_pkg.
module erm_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [erm_pkg::DIV_BITS-1:0] i_dividend,
    input  logic [erm_pkg::DIV_BITS-1:0] i_divisor,
    output logic                         o_busy,
    output logic                         o_done,
    output logic [erm_pkg::DIV_BITS-1:0] o_quot
);
    logic                          r_busy;
    logic                          r_done;
    logic [erm_pkg::STEP_BITS-1:0] r_step;
    logic [erm_pkg::DIV_BITS-1:0]  r_quo;
    logic [erm_pkg::DIV_BITS:0]    r_rem;
    logic [erm_pkg::DIV_BITS-1:0]  r_dvs;
    logic [erm_pkg::DIV_BITS:0]    trial;
    logic                          fits;

    assign trial  = {r_rem[erm_pkg::DIV_BITS-1:0], r_quo[erm_pkg::DIV_BITS-1]};
    assign fits   = (trial >= {1'b0, r_dvs});
    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quo;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? (trial - {1'b0, r_dvs}) : trial;
            r_quo <= {r_quo[erm_pkg::DIV_BITS-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= erm_pkg::STEP_BITS'(erm_pkg::DIV_BITS);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == erm_pkg::STEP_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule

### hw/rtl/erm_back.sv
// Back end of the event rate meter: event ring, configuration registers,
// snapshot sequencer and result register. Depends on erm_pkg and erm_div.
module erm_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cmd_valid,
    input  erm_pkg::t_cmd                    i_cmd,
    output logic                             o_cmd_take,
    input  logic                             i_cfg_we,
    input  logic [erm_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [erm_pkg::CFG_BITS-1:0]     i_cfg_wdata,
    output logic                             empty,
    input  logic                             pop,
    output erm_pkg::t_out_item               o_item
);
    localparam int PB = erm_pkg::PTR_BITS;
    localparam int CB = erm_pkg::CNT_BITS;
    localparam int DB = erm_pkg::DIV_BITS;
    localparam int TB = erm_pkg::TIME_BITS;
    localparam int RB = erm_pkg::RATE_BITS;

    logic [TB-1:0] r_ring [erm_pkg::RING_DEPTH];
    logic [TB-1:0] r_rdata;

    erm_pkg::t_state r_state;
    erm_pkg::t_state n_state;
    erm_pkg::t_cmd   r_cmd;

    logic [erm_pkg::WIN_BITS-1:0]    r_short_win;
    logic [erm_pkg::WIN_BITS-1:0]    r_long_win;
    logic [erm_pkg::RECENT_BITS-1:0] r_recent_secs;
    logic [TB-1:0]                   r_start_time;
    logic                            r_start_valid;

    logic [PB-1:0] r_slot;
    logic [CB-1:0] r_count;
    logic [DB-1:0] r_cut_r;
    logic [DB-1:0] r_cut_h;
    logic [erm_pkg::HQ_BITS-1:0] r_hq;
    logic [TB-1:0] r_newest;
    logic [TB-1:0] r_old_s;
    logic [TB-1:0] r_old_l;
    logic [RB-1:0] r_srate;
    logic [RB-1:0] r_lrate;
    logic [RB-1:0] r_avg;
    logic [CB-1:0] r_k;
    logic [CB-1:0] r_cnt_r;
    logic [CB-1:0] r_cnt_h;
    logic          r_alive_r;
    logic          r_alive_h;
    logic          r_ovalid;
    erm_pkg::t_out_item r_out;

    logic [erm_pkg::WIN_BITS-1:0] win_s;
    logic [erm_pkg::WIN_BITS-1:0] win_l;
    logic [TB:0]   span_s;
    logic [TB:0]   span_l;
    logic [TB:0]   total;
    logic          ok_s;
    logic          ok_l;
    logic          ok_a;
    logic [22:0]   num_s;
    logic [22:0]   num_l;
    logic [22:0]   num_a;
    logic [2*TB-8:0] hq_prod;
    logic [TB:0]   hour_base;
    logic [TB:0]   hour_off;
    logic [PB-1:0] rd_addr;
    logic          div_start;
    logic [DB-1:0] div_dvd;
    logic [DB-1:0] div_dvs;
    logic          div_busy;
    logic          div_done;
    logic [DB-1:0] div_quot;
    logic          out_free;
    logic          walk_go;
    logic          hit_r;
    logic          hit_h;

    erm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    always_comb begin
        win_s  = (r_short_win < erm_pkg::WIN_BITS'(r_count)) ? r_short_win
                                                              : erm_pkg::WIN_BITS'(r_count);
        win_l  = (r_long_win < erm_pkg::WIN_BITS'(r_count)) ? r_long_win
                                                             : erm_pkg::WIN_BITS'(r_count);
        span_s = {1'b0, r_newest} - {1'b0, r_old_s};
        span_l = {1'b0, r_newest} - {1'b0, r_old_l};
        total  = {1'b0, r_cmd.now_time} - {1'b0, r_start_time};
        ok_s   = (win_s >= erm_pkg::WIN_BITS'(2)) && !span_s[TB] && (span_s != '0);
        ok_l   = (win_l >= erm_pkg::WIN_BITS'(2)) && !span_l[TB] && (span_l != '0);
        ok_a   = r_start_valid && (r_count != '0) && !total[TB] && (total != '0);
        num_s  = 23'(win_s - 1'b1) * 23'(erm_pkg::SECS_PER_HOUR);
        num_l  = 23'(win_l - 1'b1) * 23'(erm_pkg::SECS_PER_HOUR);
        num_a  = 23'(r_count) * 23'(erm_pkg::SECS_PER_HOUR);
        hq_prod   = (2*TB-7)'(r_cmd.now_time[TB-1:4]) * (2*TB-7)'(erm_pkg::HOUR_RECIP);
        hour_base = (TB+1)'(r_hq) * (TB+1)'(erm_pkg::SECS_PER_HOUR);
        hour_off  = {1'b0, r_cmd.now_time} - hour_base;
        out_free = !r_ovalid || pop;
        walk_go  = (r_k < r_count) && (r_alive_r || r_alive_h);
        hit_r    = $signed(DB'(r_rdata)) >= $signed(r_cut_r);
        hit_h    = $signed(DB'(r_rdata)) >= $signed(r_cut_h);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            erm_pkg::S_IDLE:   if (i_cmd_valid) n_state = erm_pkg::S_APPLY;
            erm_pkg::S_APPLY:  n_state = erm_pkg::S_HDIV;
            erm_pkg::S_HDIV:   n_state = erm_pkg::S_HWAIT;
            erm_pkg::S_HWAIT:  n_state = erm_pkg::S_RNEW;
            erm_pkg::S_RNEW:   n_state = erm_pkg::S_RSHORT;
            erm_pkg::S_RSHORT: n_state = erm_pkg::S_RLONG;
            erm_pkg::S_RLONG:  n_state = erm_pkg::S_GOTL;
            erm_pkg::S_GOTL:   n_state = erm_pkg::S_DSHORT;
            erm_pkg::S_DSHORT: n_state = ok_s ? erm_pkg::S_WSHORT : erm_pkg::S_DLONG;
            erm_pkg::S_WSHORT: if (div_done) n_state = erm_pkg::S_DLONG;
            erm_pkg::S_DLONG:  n_state = ok_l ? erm_pkg::S_WLONG : erm_pkg::S_DAVG;
            erm_pkg::S_WLONG:  if (div_done) n_state = erm_pkg::S_DAVG;
            erm_pkg::S_DAVG:   n_state = ok_a ? erm_pkg::S_WAVG : erm_pkg::S_WADDR;
            erm_pkg::S_WAVG:   if (div_done) n_state = erm_pkg::S_WADDR;
            erm_pkg::S_WADDR:  n_state = walk_go ? erm_pkg::S_WCMP : erm_pkg::S_DONE;
            erm_pkg::S_WCMP:   n_state = erm_pkg::S_WADDR;
            erm_pkg::S_DONE:   if (out_free) n_state = erm_pkg::S_IDLE;
            default:           n_state = erm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_take = 1'b0;
        div_start  = 1'b0;
        div_dvd    = '0;
        div_dvs    = '0;
        rd_addr    = r_slot - PB'(1) - r_k[PB-1:0];
        case (r_state)
            erm_pkg::S_IDLE:   o_cmd_take = i_cmd_valid;
            erm_pkg::S_RNEW:   rd_addr = r_slot - PB'(1);
            erm_pkg::S_RSHORT: rd_addr = r_slot - win_s[PB-1:0];
            erm_pkg::S_RLONG:  rd_addr = r_slot - win_l[PB-1:0];
            erm_pkg::S_DSHORT: begin
                div_start = ok_s;
                div_dvd   = DB'({num_s, 1'b0}) + DB'(span_s[TB-1:0]);
                div_dvs   = {1'b0, span_s[TB-1:0], 1'b0};
            end
            erm_pkg::S_DLONG: begin
                div_start = ok_l;
                div_dvd   = DB'({num_l, 1'b0}) + DB'(span_l[TB-1:0]);
                div_dvs   = {1'b0, span_l[TB-1:0], 1'b0};
            end
            erm_pkg::S_DAVG: begin
                div_start = ok_a;
                div_dvd   = DB'({num_a, 1'b0}) + DB'(total[TB-1:0]);
                div_dvs   = {1'b0, total[TB-1:0], 1'b0};
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == erm_pkg::S_APPLY) && r_cmd.add) begin
            r_ring[r_slot] <= r_cmd.event_time;
        end
        r_rdata <= r_ring[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            erm_pkg::S_IDLE: if (i_cmd_valid) r_cmd <= i_cmd;
            erm_pkg::S_APPLY: begin
                r_srate   <= '0;
                r_lrate   <= '0;
                r_avg     <= '0;
                r_k       <= '0;
                r_cnt_r   <= '0;
                r_cnt_h   <= '0;
                r_alive_r <= 1'b1;
                r_alive_h <= 1'b1;
                r_cut_r   <= DB'(r_cmd.now_time) - DB'(r_recent_secs);
            end
            erm_pkg::S_HDIV:   r_hq <= hq_prod[2*TB-8:TB+4];
            erm_pkg::S_HWAIT: begin
                if (hour_off >= (TB+1)'(erm_pkg::SECS_PER_HOUR)) begin
                    r_cut_h <= DB'(hour_base) + DB'(erm_pkg::SECS_PER_HOUR);
                end else begin
                    r_cut_h <= DB'(hour_base);
                end
            end
            erm_pkg::S_RSHORT: r_newest <= r_rdata;
            erm_pkg::S_RLONG:  r_old_s <= r_rdata;
            erm_pkg::S_GOTL:   r_old_l <= r_rdata;
            erm_pkg::S_WSHORT: if (div_done) r_srate <= div_quot[RB-1:0];
            erm_pkg::S_WLONG:  if (div_done) r_lrate <= div_quot[RB-1:0];
            erm_pkg::S_WAVG:   if (div_done) r_avg <= div_quot[RB-1:0];
            erm_pkg::S_WCMP: begin
                r_k <= r_k + 1'b1;
                if (r_alive_r) begin
                    if (hit_r) r_cnt_r <= r_cnt_r + 1'b1;
                    else       r_alive_r <= 1'b0;
                end
                if (r_alive_h) begin
                    if (hit_h) r_cnt_h <= r_cnt_h + 1'b1;
                    else       r_alive_h <= 1'b0;
                end
            end
            erm_pkg::S_DONE: begin
                if (out_free) begin
                    r_out.short_rate   <= r_srate;
                    r_out.long_rate    <= r_lrate;
                    r_out.recent_count <= r_cnt_r;
                    r_out.hour_count   <= r_cnt_h;
                    r_out.average_rate <= r_avg;
                    r_out.total_events <= r_count;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= erm_pkg::S_IDLE;
            r_slot        <= '0;
            r_count       <= '0;
            r_ovalid      <= 1'b0;
            r_short_win   <= erm_pkg::WIN_BITS'(10);
            r_long_win    <= erm_pkg::WIN_BITS'(100);
            r_recent_secs <= erm_pkg::RECENT_BITS'(3600);
            r_start_time  <= '0;
            r_start_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == erm_pkg::S_APPLY) begin
                if (r_cmd.add) begin
                    r_slot <= r_slot + 1'b1;
                    if (r_count < CB'(erm_pkg::RING_DEPTH)) begin
                        r_count <= r_count + 1'b1;
                    end
                end else if (r_cmd.clear) begin
                    r_slot  <= '0;
                    r_count <= '0;
                end
            end
            if ((r_state == erm_pkg::S_DONE) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (pop) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    erm_pkg::CFG_SHORT_WIN:
                        r_short_win <= i_cfg_wdata[erm_pkg::WIN_BITS-1:0];
                    erm_pkg::CFG_LONG_WIN:
                        r_long_win <= i_cfg_wdata[erm_pkg::WIN_BITS-1:0];
                    erm_pkg::CFG_RECENT_SECS:
                        r_recent_secs <= i_cfg_wdata[erm_pkg::RECENT_BITS-1:0];
                    erm_pkg::CFG_START_TIME:
                        r_start_time <= i_cfg_wdata[TB-1:0];
                    erm_pkg::CFG_START_VALID:
                        r_start_valid <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
        end
    end

    assign empty  = !r_ovalid;
    assign o_item = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CB'(erm_pkg::RING_DEPTH))
        else $error("Stored event count exceeds the ring depth.");
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == erm_pkg::S_WADDR) |-> (r_cnt_r <= r_k) && (r_cnt_h <= r_k))
        else $error("Window count exceeds the number of entries walked.");
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_busy)
        else $error("Divider started while busy.");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == erm_pkg::S_APPLY) && r_cmd.clear && !r_cmd.add |=> (r_count == '0))
        else $error("Clear did not empty the ring.");
endmodule

### hw/rtl/event_rate_meter_unit.sv
// Top level of the event rate meter: input queue front end and snapshot
// back end. Depends on erm_pkg, erm_front and erm_back.
//
//  channel   direction  handshake             payload
//  input     in         push / full           i_item (erm_pkg::t_in_item)
//  result    out        empty / pop           o_item (erm_pkg::t_out_item)
//  config    in         i_cfg_we, i_cfg_idx   i_cfg_wdata
//
// Each item walks k entries (at most the stored count) with an address state and a
// compare state per entry, as the single ring read port serves one entry at a time,
// and up to three 34-step divisions share one divider. The hour start comes from a
// reciprocal multiply.
// Reset is synchronous and empties the ring; no clearing pass is needed.
// Two input items queue ahead of the sequencer and one result waits behind it.
module event_rate_meter_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  erm_pkg::t_in_item                i_item,
    output logic                             empty,
    input  logic                             pop,
    output erm_pkg::t_out_item               o_item,
    input  logic                             i_cfg_we,
    input  logic [erm_pkg::CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [erm_pkg::CFG_BITS-1:0]     i_cfg_wdata
);
    logic          cmd_valid;
    logic          cmd_take;
    erm_pkg::t_cmd cmd;

    erm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    erm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .empty       (empty),
        .pop         (pop),
        .o_item      (o_item)
    );
endmodule

### verif/tb.sv
// Self-checking testbench for event_rate_meter_unit: a directed stimulus table,
// then random runs under several register settings, checked against a behavioral
// rate predictor or typed table snapshots. Depends on erm_pkg and the RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 20000;
    localparam int SETTLE = 2500;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             push;
    logic                             full;
    erm_pkg::t_in_item                i_item;
    logic                             empty;
    logic                             pop;
    erm_pkg::t_out_item               o_item;
    logic                             i_cfg_we;
    logic [erm_pkg::CFG_IDX_BITS-1:0] i_cfg_idx;
    logic [erm_pkg::CFG_BITS-1:0]     i_cfg_wdata;

    event_rate_meter_unit uut (.*);

    typedef struct {
        logic [1:0]         op;
        logic [31:0]        ev;
        logic [31:0]        now;
        bit                 typed;
        erm_pkg::t_out_item snap;
    } t_row;

    logic [erm_pkg::TIME_BITS-1:0] ring_times [erm_pkg::RING_DEPTH];
    int unsigned          next_slot;
    int unsigned          held_events;
    int unsigned          short_win;
    int unsigned          long_win;
    int unsigned          recent_secs;
    longint               start_secs;
    bit                   start_ok;

    erm_pkg::t_out_item snapshot_q [$];
    int        errors;
    int        idle_cycles;
    int        pop_stall;
    bit        hold_req;
    bit        quiet;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint newest(int unsigned k);
        return longint'({32'd0, ring_times[(next_slot + erm_pkg::RING_DEPTH - 1 - k)
                                           % erm_pkg::RING_DEPTH]});
    endfunction

    function automatic longint span_rate(int unsigned win);
        int unsigned n;
        longint      span;
        longint      num;
        n = (win < held_events) ? win : held_events;
        if (n < 2) return 0;
        span = newest(0) - newest(n - 1);
        if (span <= 0) return 0;
        num = longint'(n - 1) * 3600;
        return (2 * num + span) / (2 * span);
    endfunction

    function automatic int unsigned events_since(longint cutoff);
        int unsigned c;
        c = 0;
        for (int unsigned k = 0; k < held_events; k++) begin
            if (newest(k) < cutoff) break;
            c++;
        end
        return c;
    endfunction

    function automatic erm_pkg::t_out_item predict_snapshot(erm_pkg::t_in_item it);
        erm_pkg::t_out_item r;
        longint    now;
        longint    elapsed;
        longint    num;
        r = '0;
        now = longint'({32'd0, it.now_time});
        if (it.op == erm_pkg::OP_ADD) begin
            ring_times[next_slot] = it.event_time;
            next_slot = (next_slot + 1) % erm_pkg::RING_DEPTH;
            if (held_events < erm_pkg::RING_DEPTH) held_events++;
        end else if (it.op == erm_pkg::OP_CLEAR) begin
            next_slot = 0;
            held_events = 0;
        end
        if (held_events > 0) begin
            r.short_rate = erm_pkg::RATE_BITS'(span_rate(short_win));
            r.long_rate = erm_pkg::RATE_BITS'(span_rate(long_win));
            r.recent_count = erm_pkg::CNT_BITS'(events_since(now - longint'(recent_secs)));
            r.hour_count = erm_pkg::CNT_BITS'(events_since(now - (now % 3600)));
            elapsed = now - start_secs;
            if (start_ok && elapsed > 0) begin
                num = longint'(held_events) * 3600;
                r.average_rate = erm_pkg::RATE_BITS'((2 * num + elapsed) / (2 * elapsed));
            end
        end
        r.total_events = erm_pkg::CNT_BITS'(held_events);
        return r;
    endfunction

    task automatic send(erm_pkg::t_in_item it, bit typed, erm_pkg::t_out_item snap);
        erm_pkg::t_out_item p;
        int        gap;
        gap = quiet ? 0 : $urandom_range(0, 9);
        repeat (gap) begin
            @(negedge i_clk);
            push <= 1'b0;
        end
        @(negedge i_clk);
        push <= 1'b1;
        i_item <= it;
        forever begin
            @(posedge i_clk);
            if (!full) break;
        end
        p = predict_snapshot(it);
        snapshot_q.push_back(typed ? snap : p);
        if ($urandom_range(0, 19) == 0) quiet = ~quiet;
    endtask

    task automatic settle();
        @(negedge i_clk);
        push <= 1'b0;
        wait (snapshot_q.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_regs(logic [31:0] sw, logic [31:0] lw, logic [31:0] rs,
                              logic [31:0] st, logic [31:0] sv);
        logic [31:0] vals [5];
        vals = '{sw, lw, rs, st, sv};
        for (int i = 0; i < 5; i++) begin
            @(negedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_idx <= erm_pkg::CFG_IDX_BITS'(i);
            i_cfg_wdata <= vals[i];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        short_win = 32'(sw[erm_pkg::WIN_BITS-1:0]);
        long_win = 32'(lw[erm_pkg::WIN_BITS-1:0]);
        recent_secs = 32'(rs[erm_pkg::RECENT_BITS-1:0]);
        start_secs = longint'({32'd0, st});
        start_ok = sv[0];
    endtask

    task automatic random_run(int count);
        erm_pkg::t_in_item it;
        logic [31:0] clock_now;
        int          pick;
        clock_now = $urandom_range(0, 20000);
        for (int i = 0; i < count; i++) begin
            pick = $urandom_range(0, 99);
            clock_now += $urandom_range(0, 400);
            it.event_time = clock_now;
            it.now_time = clock_now + $urandom_range(0, 100);
            it.op = (pick < 85) ? erm_pkg::OP_ADD : (pick < 95) ? erm_pkg::OP_REFRESH :
                    (pick < 98) ? erm_pkg::OP_CLEAR : erm_pkg::OP_SPARE;
            if ($urandom_range(0, 9) == 0) begin
                it.event_time = $urandom;
                it.now_time = $urandom;
            end
            send(it, 1'b0, '0);
        end
    endtask

    function automatic erm_pkg::t_out_item snap_of(int rec, int hr, int tot);
        erm_pkg::t_out_item s;
        s = '0;
        s.recent_count = erm_pkg::CNT_BITS'(rec);
        s.hour_count = erm_pkg::CNT_BITS'(hr);
        s.total_events = erm_pkg::CNT_BITS'(tot);
        return s;
    endfunction

    task automatic cmp_field(string name, int unsigned e, int unsigned a);
        if (e != a) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, e, a);
            errors++;
        end
    endtask

    always @(negedge i_clk) begin
        if (hold_req) begin
            pop <= 1'b0;
            repeat (3000) @(negedge i_clk);
            hold_req = 1'b0;
        end else if (pop_stall > 0) begin
            pop <= 1'b0;
            pop_stall--;
        end else begin
            pop <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= LIMIT) begin
            $display("tb: done, errors");
            $finish;
        end
        if (i_rst_n && pop && !empty) begin
            if (snapshot_q.size() == 0) begin
                $display("%0t: transfer with no snapshot expected", $time);
                errors++;
            end else begin
                erm_pkg::t_out_item e;
                e = snapshot_q.pop_front();
                cmp_field("short_rate", 32'(e.short_rate), 32'(o_item.short_rate));
                cmp_field("long_rate", 32'(e.long_rate), 32'(o_item.long_rate));
                cmp_field("recent_count", 32'(e.recent_count), 32'(o_item.recent_count));
                cmp_field("hour_count", 32'(e.hour_count), 32'(o_item.hour_count));
                cmp_field("average_rate", 32'(e.average_rate), 32'(o_item.average_rate));
                cmp_field("total_events", 32'(e.total_events), 32'(o_item.total_events));
            end
            pop_stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
        end
    end

    initial begin
        t_row     rows [$];
        erm_pkg::t_in_item it;
        errors = 0;
        idle_cycles = 0;
        pop_stall = 0;
        hold_req = 1'b0;
        quiet = 1'b0;
        i_rst_n = 1'b0;
        push = 1'b0;
        i_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_wdata = '0;
        next_slot = 0;
        held_events = 0;
        short_win = 10;
        long_win = 100;
        recent_secs = 3600;
        start_secs = 0;
        start_ok = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        rows = '{
            '{erm_pkg::OP_REFRESH, 32'd0, 32'd0, 1'b1, snap_of(0, 0, 0)},
            '{erm_pkg::OP_ADD, 32'd1000, 32'd1000, 1'b1, snap_of(1, 1, 1)},
            '{erm_pkg::OP_ADD, 32'd1000, 32'd1000, 1'b0, '0},
            '{erm_pkg::OP_ADD, 32'd1360, 32'd1400, 1'b0, '0},
            '{erm_pkg::OP_ADD, 32'd500, 32'd1400, 1'b0, '0},
            '{erm_pkg::OP_SPARE, 32'hFFFF_FFFF, 32'd3599, 1'b0, '0},
            '{erm_pkg::OP_REFRESH, 32'd0, 32'd3600, 1'b0, '0},
            '{erm_pkg::OP_CLEAR, 32'd77, 32'd5000, 1'b1, snap_of(0, 0, 0)},
            '{erm_pkg::OP_ADD, 32'd0, 32'd0, 1'b1, snap_of(1, 1, 1)},
            '{erm_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
            '{erm_pkg::OP_ADD, 32'd0, 32'hFFFF_FFFF, 1'b0, '0},
            '{erm_pkg::OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0},
            '{erm_pkg::OP_REFRESH, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0},
            '{erm_pkg::OP_CLEAR, 32'd0, 32'd0, 1'b1, snap_of(0, 0, 0)},
            '{erm_pkg::OP_SPARE, 32'd0, 32'd0, 1'b1, snap_of(0, 0, 0)}
        };
        foreach (rows[i]) begin
            it.op = rows[i].op;
            it.event_time = rows[i].ev;
            it.now_time = rows[i].now;
            send(it, rows[i].typed, rows[i].snap);
        end
        settle();

        write_regs(32'hFFFF_F802, 32'd1024, 32'd86400, 32'd1000, 32'd1);
        hold_req = 1'b1;
        random_run(65);
        settle();
        write_regs(32'd1024, 32'd2, 32'd1, 32'hFFFF_FFFF, 32'd1);
        random_run(65);
        settle();
        write_regs(32'd0, 32'd1, 32'h0001_FFFF, 32'd0, 32'hFFFF_FFFE);
        random_run(65);
        settle();
        write_regs(32'd10, 32'd1024, 32'd86400, 32'd50, 32'd1);
        it.op = erm_pkg::OP_REFRESH;
        it.event_time = 32'd0;
        it.now_time = 32'd5000;
        send(it, 1'b0, '0);
        random_run(64);
        settle();

        if (errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

endmodule
